FILE: design/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

    // item kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_READ_CODE  = 2'd0;
    localparam logic [1:0] REG_WRITE_CODE = 2'd1;
    localparam logic [1:0] REG_BURST_CODE = 2'd2;
    localparam logic [1:0] REG_ERROR_CODE = 2'd3;

    // error status codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_CRC     = 2'd2;
    localparam logic [1:0] ERR_FINAL   = 2'd3;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [8:0]  HDR_BYTES = 9'd5;
    localparam logic [8:0]  COUNT_MAX = 9'd511;
    localparam logic [8:0]  NO_PAY_END = 9'd9;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic        packet_done;
        logic [1:0]  error_status;
        logic [3:0]  command;
        logic [27:0] address;
        logic [8:0]  length;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
    } t_out_item;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [3:0] reg_data;
    } t_cfg_write;

    typedef struct packed {
        logic [3:0] read_code;
        logic [3:0] write_code;
        logic [3:0] read_burst_code;
        logic [3:0] error_code;
    } t_codes;

endpackage

`default_nettype wire

FILE: design/cpd_stream_if.sv
`default_nettype none

interface cpd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/cpd_crc_byte.sv
`default_nettype none

module cpd_crc_byte (
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);
    import cpd_pkg::*;

    // reflected crc-32, one byte, lsb first
    always_comb begin
        logic [31:0] v_crc;
        v_crc = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            v_crc = v_crc[0] ? ((v_crc >> 1) ^ CRC_POLY) : (v_crc >> 1);
        end
        o_crc = v_crc;
    end
endmodule

`default_nettype wire

FILE: design/cpd_core.sv
`default_nettype none

module cpd_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire cpd_pkg::t_in_item  i_item,
    input  wire cpd_pkg::t_codes    i_codes,
    output cpd_pkg::t_out_item      o_result
);
    import cpd_pkg::*;

    localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

    logic [8:0]  r_byte_count, n_byte_count;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rx_crc, n_rx_crc;
    logic [3:0]  r_command, n_command;
    logic [27:0] r_address, n_address;
    logic [8:0]  r_length, n_length;
    logic        r_done, n_done;
    logic [1:0]  r_error, n_error;
    logic [27:0] r_hdr_shift, n_hdr_shift;

    logic [31:0] crc_upd;
    logic        no_pay, pay, in_payload;
    logic [8:0]  count_next;
    logic [9:0]  pay_end;
    logic [3:0]  nib;
    logic        pv;
    logic [7:0]  pb, pi;

    cpd_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_item.byte_value),
        .o_crc  (crc_upd)
    );

    assign no_pay = (r_command == i_codes.write_code) || (r_command == i_codes.error_code);
    assign pay    = !no_pay && ((r_command == i_codes.read_code)
                                || (r_command == i_codes.read_burst_code));
    assign pay_end    = {1'b0, r_length} + {1'b0, HDR_BYTES};
    assign in_payload = pay && ({1'b0, r_byte_count} < pay_end);
    assign count_next = r_byte_count + 9'd1;
    assign nib        = i_item.byte_value[7:4];

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_rx_crc     = r_rx_crc;
        n_command    = r_command;
        n_address    = r_address;
        n_length     = r_length;
        n_done       = r_done;
        n_error      = r_error;
        n_hdr_shift  = r_hdr_shift;
        pv           = 1'b0;
        pb           = 8'd0;
        pi           = 8'd0;
        case (i_item.kind)
            KIND_FINAL: begin
                n_error = ERR_FINAL;
                n_done  = 1'b1;
            end
            KIND_CLEAR: begin
                n_byte_count = 9'd0;
                n_crc        = CRC_INIT;
                n_rx_crc     = 32'd0;
                n_command    = 4'd0;
                n_address    = 28'd0;
                n_length     = 9'd0;
                n_done       = 1'b0;
                n_error      = ERR_NONE;
                n_hdr_shift  = 28'd0;
            end
            KIND_BYTE: begin
                if (!r_done && r_byte_count != COUNT_MAX) begin
                    n_byte_count = count_next;
                    if (r_byte_count < HDR_BYTES) begin
                        n_crc = crc_upd;
                        if (r_byte_count == 9'd0) begin
                            if (nib == i_codes.read_code || nib == i_codes.write_code
                                || nib == i_codes.read_burst_code
                                || nib == i_codes.error_code) begin
                                n_command = nib;
                            end else begin
                                n_error = ERR_UNKNOWN;
                                n_done  = 1'b1;
                            end
                            n_hdr_shift = {24'd0, i_item.byte_value[3:0]};
                        end else if (r_byte_count < 9'd4) begin
                            n_hdr_shift = {r_hdr_shift[19:0], i_item.byte_value};
                            if (r_byte_count == 9'd3) begin
                                n_address = {r_hdr_shift[19:0], i_item.byte_value};
                            end
                        end else begin
                            // zero means the largest payload
                            if (i_item.byte_value == 8'd0
                                || {1'b0, i_item.byte_value} > MAX_LEN) begin
                                n_length = MAX_LEN;
                            end else begin
                                n_length = {1'b0, i_item.byte_value};
                            end
                        end
                    end else if (in_payload) begin
                        n_crc = crc_upd;
                        pv    = 1'b1;
                        pb    = i_item.byte_value;
                        pi    = 8'(r_byte_count - HDR_BYTES);
                    end else begin
                        n_rx_crc = {r_rx_crc[23:0], i_item.byte_value};
                        if ((no_pay && count_next == NO_PAY_END)
                            || (pay && {1'b0, count_next}
                                == {1'b0, r_length} + {1'b0, NO_PAY_END})) begin
                            if ({r_rx_crc[23:0], i_item.byte_value} != r_crc) begin
                                n_error = ERR_CRC;
                            end
                            n_done = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 9'd0;
            r_crc        <= CRC_INIT;
            r_rx_crc     <= 32'd0;
            r_command    <= 4'd0;
            r_address    <= 28'd0;
            r_length     <= 9'd0;
            r_done       <= 1'b0;
            r_error      <= ERR_NONE;
            r_hdr_shift  <= 28'd0;
        end else if (i_step) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_rx_crc     <= n_rx_crc;
            r_command    <= n_command;
            r_address    <= n_address;
            r_length     <= n_length;
            r_done       <= n_done;
            r_error      <= n_error;
            r_hdr_shift  <= n_hdr_shift;
        end
    end

    always_comb begin
        o_result.packet_done   = n_done;
        o_result.error_status  = n_error;
        o_result.command       = n_command;
        o_result.address       = n_address;
        o_result.length        = n_length;
        o_result.payload_valid = pv;
        o_result.payload_byte  = pb;
        o_result.payload_index = pi;
    end

`ifndef SYNTHESIS
    a_done_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.kind == KIND_BYTE && r_done)
        |=> ($stable(r_byte_count) && $stable(r_crc) && $stable(r_error)))
        else $error("byte changed state after packet done");

    a_payload_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.payload_valid |-> (r_byte_count >= HDR_BYTES && !r_done))
        else $error("payload byte flagged inside header or after done");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.kind == KIND_CLEAR)
        |=> (r_byte_count == 9'd0 && r_crc == CRC_INIT && !r_done && r_error == ERR_NONE))
        else $error("clear left state behind");
`endif
endmodule

`default_nettype wire

FILE: design/command_packet_deframer_crc32.sv
// command packet deframer with crc-32 check
// channels:
//   i_in_chan  - one transfer per received byte, finalize or clear (kind field)
//   o_out_chan - one status transfer for every input transfer, in order
//   i_cfg_chan - register writes (read, write, burst read, error command codes),
//                always ready, to be used only while no item is in flight
// path: an input transfer is held in the input register, then its result
//   is offered from the result register
// throughput: one item per cycle while the receiver keeps up; the byte-wide
//   crc update and header/length counter settle between the two registers
// reset (i_rst_n low, synchronous): parser state cleared, crc to all ones,
//   command codes back to 1, 2, 3 and 15, both channels empty
// stall: while the receiver holds off, the result register holds and the
//   input register still takes one more transfer, then i_in_chan.ready drops
`default_nettype none

module command_packet_deframer_crc32 #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cpd_stream_if.sink   i_in_chan,
    cpd_stream_if.source o_out_chan,
    cpd_stream_if.sink   i_cfg_chan
);
    import cpd_pkg::*;

    // input stage
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    // result stage
    logic      r_out_valid;
    t_out_item r_out_item;
    // command codes
    t_codes    r_codes;

    logic      advance;
    logic      step;
    t_out_item result;

    // result register moves when empty or taken
    assign advance = !r_out_valid || o_out_chan.ready;
    assign step    = r_s1_valid && advance;

    assign i_in_chan.ready  = !r_s1_valid || advance;
    assign i_cfg_chan.ready = 1'b1;

    assign o_out_chan.valid   = r_out_valid;
    assign o_out_chan.payload = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_chan.ready) begin
            r_s1_valid <= i_in_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_chan.ready && i_in_chan.valid) begin
            r_s1_item <= i_in_chan.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    // register write on each cfg transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.read_code       <= 4'd1;
            r_codes.write_code      <= 4'd2;
            r_codes.read_burst_code <= 4'd3;
            r_codes.error_code      <= 4'd15;
        end else if (i_cfg_chan.valid) begin
            case (i_cfg_chan.payload.reg_index)
                REG_READ_CODE:  r_codes.read_code       <= i_cfg_chan.payload.reg_data;
                REG_WRITE_CODE: r_codes.write_code      <= i_cfg_chan.payload.reg_data;
                REG_BURST_CODE: r_codes.read_burst_code <= i_cfg_chan.payload.reg_data;
                REG_ERROR_CODE: r_codes.error_code      <= i_cfg_chan.payload.reg_data;
                default: begin
                end
            endcase
        end
    end

    // parser: header, payload, trailer and crc check, one byte per step
    cpd_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_s1_item),
        .i_codes  (r_codes),
        .o_result (result)
    );
endmodule

`default_nettype wire

FILE: tb/sv/tb_command_packet_deframer_crc32.sv
module tb_command_packet_deframer_crc32;
    timeunit 1ns;
    timeprecision 1ps;

    import cpd_pkg::*;

    // kind value the block leaves unused
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int MAX_PAYLOAD  = 256;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_ITEMS  = 25;
    localparam int CYCLE_LIMIT  = 400000;

    // running copy of the deframer: parser state, command codes and the
    // statuses still owed by the block, oldest first
    class deframer_status_board;
        t_codes      codes;
        logic [8:0]  n_bytes;
        logic [31:0] crc_run;
        logic [31:0] crc_rx;
        logic [3:0]  cmd;
        logic [27:0] addr;
        logic [27:0] hdr;
        logic [8:0]  len;
        logic        done;
        logic [1:0]  err;
        t_out_item   status_due[$];
        int          faults;

        function new();
            codes  = '{read_code: 4'd1, write_code: 4'd2, read_burst_code: 4'd3,
                       error_code: 4'd15};
            faults = 0;
            restart();
        endfunction

        static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
            c = c ^ {24'd0, b};
            for (int i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void restart();
            n_bytes = '0;
            crc_run = CRC_INIT;
            crc_rx  = '0;
            cmd     = '0;
            addr    = '0;
            hdr     = '0;
            len     = '0;
            done    = 1'b0;
            err     = ERR_NONE;
        endfunction

        function bit is_code(logic [3:0] nib);
            return nib == codes.read_code || nib == codes.write_code ||
                   nib == codes.read_burst_code || nib == codes.error_code;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                REG_READ_CODE:  codes.read_code       = val;
                REG_WRITE_CODE: codes.write_code      = val;
                REG_BURST_CODE: codes.read_burst_code = val;
                REG_ERROR_CODE: codes.error_code      = val;
                default: ;
            endcase
        endfunction

        function void take_item(t_in_item it);
            t_out_item r;
            int        idx;
            bit        no_pay;
            bit        pay;
            r = '0;
            case (it.kind)
                KIND_FINAL: begin
                    err  = ERR_FINAL;
                    done = 1'b1;
                end
                KIND_CLEAR: restart();
                KIND_BYTE: if (!done && n_bytes < COUNT_MAX) begin
                    idx    = n_bytes;
                    no_pay = cmd == codes.write_code || cmd == codes.error_code;
                    pay    = !no_pay &&
                             (cmd == codes.read_code || cmd == codes.read_burst_code);
                    n_bytes = n_bytes + 9'd1;
                    if (idx < HDR_BYTES) begin
                        crc_run = crc_next(crc_run, it.byte_value);
                        if (idx == 0) begin
                            if (is_code(it.byte_value[7:4])) begin
                                cmd = it.byte_value[7:4];
                            end else begin
                                err  = ERR_UNKNOWN;
                                done = 1'b1;
                            end
                            hdr = {24'd0, it.byte_value[3:0]};
                        end else if (idx < 4) begin
                            hdr = {hdr[19:0], it.byte_value};
                            if (idx == 3)
                                addr = hdr;
                        end else begin
                            len = (it.byte_value == 8'd0) ? 9'(MAX_PAYLOAD)
                                                          : {1'b0, it.byte_value};
                        end
                    end else if (pay && idx < HDR_BYTES + len) begin
                        crc_run         = crc_next(crc_run, it.byte_value);
                        r.payload_valid = 1'b1;
                        r.payload_byte  = it.byte_value;
                        r.payload_index = 8'(idx - 5);
                    end else begin
                        crc_rx = {crc_rx[23:0], it.byte_value};
                        if ((no_pay && n_bytes == NO_PAY_END) ||
                            (pay && n_bytes == len + NO_PAY_END)) begin
                            if (crc_rx != crc_run)
                                err = ERR_CRC;
                            done = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.packet_done  = done;
            r.error_status = err;
            r.command      = cmd;
            r.address      = addr;
            r.length       = len;
            status_due.push_back(r);
        endfunction

        function void check_status(t_out_item got);
            t_out_item want;
            if (status_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("status transfer with nothing outstanding: %p", got);
                return;
            end
            want = status_due.pop_front();
            if (got.packet_done !== want.packet_done ||
                got.error_status !== want.error_status ||
                got.command !== want.command || got.address !== want.address ||
                got.length !== want.length || got.payload_valid !== want.payload_valid ||
                got.payload_byte !== want.payload_byte ||
                got.payload_index !== want.payload_index) begin
                faults++;
                if (faults <= 10)
                    $display({"status mismatch: done %0d/%0d err %0d/%0d cmd %h/%h ",
                              "addr %h/%h len %0d/%0d pv %0d/%0d pb %h/%h pi %0d/%0d ",
                              "(expected/actual)"},
                             want.packet_done, got.packet_done,
                             want.error_status, got.error_status,
                             want.command, got.command, want.address, got.address,
                             want.length, got.length,
                             want.payload_valid, got.payload_valid,
                             want.payload_byte, got.payload_byte,
                             want.payload_index, got.payload_index);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpd_stream_if #(.t_payload(t_in_item))   in_chan ();
    cpd_stream_if #(.t_payload(t_out_item))  out_chan ();
    cpd_stream_if #(.t_payload(t_cfg_write)) cfg_chan ();

    command_packet_deframer_crc32 #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan),
        .i_cfg_chan (cfg_chan)
    );

    deframer_status_board sb = new();

    // per-side switches for the random hold-offs, flipped between sequences
    bit in_gaps  = 1'b0;
    bit out_gaps = 1'b0;
    int items_sent = 0;
    int cycles = 0;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog: a hang or lost status ends the run here
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // status sink: while out_gaps is set, may hold ready low before each transfer,
    // then take it and check it against the oldest expectation
    initial begin
        int gap;
        out_chan.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = out_gaps ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
                out_chan.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_chan.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_chan.valid && out_chan.ready));
            sb.check_status(out_chan.payload);
            @(negedge i_clk);
        end
    end

    // one input transfer; entered and left at a falling edge, valid stays
    // high when the next transfer follows with no gap
    task automatic send_item(input logic [1:0] kind, input logic [7:0] value);
        int       gap;
        t_in_item it;
        it  = '{kind: kind, byte_value: value};
        gap = in_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_chan.valid   <= 1'b1;
        in_chan.payload <= it;
        do @(posedge i_clk); while (!(in_chan.valid && in_chan.ready));
        sb.take_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering input and wait for every status to come back
    task automatic drain();
        in_chan.valid <= 1'b0;
        while (sb.status_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register writes back to back, only with the pipe empty
    task automatic cfg_write(input logic [1:0] idx, input logic [3:0] val);
        cfg_chan.payload <= t_cfg_write'{reg_index: idx, reg_data: val};
        cfg_chan.valid   <= 1'b1;
        do @(posedge i_clk); while (!(cfg_chan.valid && cfg_chan.ready));
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic set_codes(input logic [3:0] rd, input logic [3:0] wr,
                             input logic [3:0] bu, input logic [3:0] er);
        drain();
        cfg_write(REG_READ_CODE, rd);
        cfg_write(REG_WRITE_CODE, wr);
        cfg_write(REG_BURST_CODE, bu);
        cfg_write(REG_ERROR_CODE, er);
        cfg_chan.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [3:0] code_at(input int i);
        case (i)
            0:       return sb.codes.read_code;
            1:       return sb.codes.write_code;
            2:       return sb.codes.read_burst_code;
            default: return sb.codes.error_code;
        endcase
    endfunction

    // whole packet with a correct or spoilt crc; cut >= 0 replaces byte
    // number cut with a finalize and stops there
    task automatic send_packet(input logic [3:0] nib, input logic [27:0] a,
                               input logic [7:0] len_byte, input bit corrupt,
                               input int cut);
        logic [7:0]  pkt[$];
        logic [31:0] c;
        bit          has_pay;
        int          n;
        pkt = {};
        pkt.push_back({nib, a[27:24]});
        pkt.push_back(a[23:16]);
        pkt.push_back(a[15:8]);
        pkt.push_back(a[7:0]);
        pkt.push_back(len_byte);
        has_pay = !(nib == sb.codes.write_code || nib == sb.codes.error_code) &&
                  (nib == sb.codes.read_code || nib == sb.codes.read_burst_code);
        if (has_pay) begin
            n = (len_byte == 8'd0) ? MAX_PAYLOAD : len_byte;
            repeat (n) pkt.push_back(8'($urandom));
        end
        c = CRC_INIT;
        foreach (pkt[i]) c = deframer_status_board::crc_next(c, pkt[i]);
        if (corrupt)
            c = c ^ (32'd1 << $urandom_range(0, 31));
        pkt.push_back(c[31:24]);
        pkt.push_back(c[23:16]);
        pkt.push_back(c[15:8]);
        pkt.push_back(c[7:0]);
        foreach (pkt[i]) begin
            if (i == cut) begin
                send_item(KIND_FINAL, 8'($urandom));
                break;
            end
            send_item(KIND_BYTE, pkt[i]);
        end
    endtask

    // a command the codes are moved away from mid-packet never completes;
    // keep feeding it until the byte counter saturates
    task automatic hung_packet();
        logic [3:0] stray;
        send_item(KIND_CLEAR, 8'h00);
        send_item(KIND_BYTE, {sb.codes.read_code, 4'h9});
        send_item(KIND_BYTE, 8'hA5);
        drain();
        stray = 4'd0;
        while (sb.is_code(stray)) stray++;
        cfg_write(REG_READ_CODE, stray);
        cfg_chan.valid <= 1'b0;
        @(negedge i_clk);
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        repeat (515) send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_FINAL, 8'h00);
        send_item(KIND_CLEAR, 8'h00);
    endtask

    // random sequences: mostly well-formed packets, also early finalize,
    // unknown commands, trailing junk and plain noise
    task automatic random_traffic(input int budget);
        int         stop_at;
        int         pick;
        int         cut;
        logic [3:0] nib;
        logic [7:0] len_byte;
        logic [27:0] a;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            in_gaps  = $urandom_range(0, 3) != 0;
            out_gaps = $urandom_range(0, 3) != 0;
            pick     = $urandom_range(0, 99);
            // now and then leave out the clear so the old packet swallows bytes
            if ($urandom_range(0, 9) != 0)
                send_item(KIND_CLEAR, 8'($urandom));
            nib = code_at($urandom_range(0, 3));
            a   = ($urandom_range(0, 9) == 0) ? {28{$urandom_range(0, 1) == 1}}
                                              : 28'($urandom);
            // few long payloads, the rest short
            if ($urandom_range(0, 49) == 0)
                len_byte = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'd255;
            else
                len_byte = 8'($urandom_range(1, 12));
            if (pick < 60) begin
                send_packet(nib, a, len_byte, $urandom_range(0, 4) == 0, -1);
            end else if (pick < 70) begin
                cut = $urandom_range(0, 12);
                send_packet(nib, a, len_byte, 1'b0, cut);
            end else if (pick < 80) begin
                do nib = 4'($urandom); while (sb.is_code(nib));
                send_packet(nib, a, len_byte, 1'b0, -1);
            end else if (pick < 88) begin
                send_packet(nib, a, len_byte, $urandom_range(0, 1) == 1, -1);
                repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
                if ($urandom_range(0, 1) == 1)
                    send_item(KIND_FINAL, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 10))
                    send_item(2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        int phase;
        i_rst_n          = 1'b0;
        in_chan.valid    = 1'b0;
        in_chan.payload  = '0;
        cfg_chan.valid   = 1'b0;
        cfg_chan.payload = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset codes, write and read packets at the address
        // extremes, unknown command, byte after done, finalize after done,
        // the unused kind
        send_item(KIND_CLEAR, 8'h00);
        send_packet(sb.codes.write_code, 28'hFFF_FFFF, 8'hFF, 1'b0, -1);
        send_item(KIND_CLEAR, 8'hFF);
        send_packet(sb.codes.read_code, 28'h000_0000, 8'h01, 1'b0, -1);
        send_item(KIND_CLEAR, 8'h00);
        send_item(KIND_BYTE, 8'h4A);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_FINAL, 8'h00);
        send_item(KIND_SPARE, 8'h55);

        // code settings in turn: reset values, distinct extremes, shared
        // codes, all equal at both ends, then random ones
        phase = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS || phase < 7) begin
            case (phase)
                0:       set_codes(4'd1, 4'd2, 4'd3, 4'd15);
                1:       set_codes(4'd0, 4'd15, 4'd8, 4'd7);
                2:       set_codes(4'd15, 4'd0, 4'd7, 4'd8);
                3:       set_codes(4'd5, 4'd5, 4'd6, 4'd9);
                4:       set_codes(4'd0, 4'd0, 4'd0, 4'd0);
                5:       set_codes(4'd15, 4'd15, 4'd15, 4'd15);
                default: set_codes(4'($urandom), 4'($urandom), 4'($urandom),
                                   4'($urandom));
            endcase
            if (phase == 1)
                hung_packet();
            random_traffic(PHASE_ITEMS);
            phase++;
        end

        // let every outstanding status arrive, then idle with no input before the verdict
        in_chan.valid <= 1'b0;
        while (sb.status_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (sb.faults == 0 && sb.status_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
